>>> hdl/dense_backprop_gradient_accumulator_core_defines.svh
// Assertion macros shared by the accumulator RTL.
`ifndef DENSE_BACKPROP_GRADIENT_ACCUMULATOR_CORE_DEFINES_SVH
`define DENSE_BACKPROP_GRADIENT_ACCUMULATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Check on every clock edge outside reset.
`define DBGA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Check on every clock edge, reset included.
`define DBGA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define DBGA_ASSERT(lbl, prop, msg)
`define DBGA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> hdl/dbga_pkg.sv
// Types and constants of the dense-layer backprop gradient accumulator.
package dbga_pkg;

    localparam int MAX_OUTPUTS = 256;
    localparam int FRAC_BITS   = 12;
    localparam int ACC_W       = 40;
    localparam int GRAD_W      = 16;
    localparam int IDX_W       = 8;
    localparam int DERIV_W     = 8;
    localparam int PROD_W      = 2 * GRAD_W;
    localparam int ADDR_W      = $clog2(MAX_OUTPUTS);
    localparam int SHIFT_W     = ACC_W - FRAC_BITS;
    localparam int SCALE_W     = SHIFT_W + DERIV_W + 1;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = $clog2(FIFO_DEPTH) + 1;

    localparam logic [IDX_W:0] OUT_LIMIT = (IDX_W + 1)'(MAX_OUTPUTS);

    // Clip bounds of the scaled emit value
    localparam logic signed [SCALE_W-1:0] SAT_HI = SCALE_W'(2 ** (GRAD_W - 1) - 1);
    localparam logic signed [SCALE_W-1:0] SAT_LO = -SAT_HI - SCALE_W'(1);

    typedef enum logic {
        CMD_ACC  = 1'b0,
        CMD_EMIT = 1'b1
    } t_cmd;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_acc_rd;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [ACC_W-1:0]  data;
    } t_acc_wr;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [GRAD_W-1:0] grad;
        logic              sat;
    } t_result;

endpackage

>>> hdl/dense_backprop_gradient_accumulator_core.sv
// Top level of the dense-layer backprop gradient accumulator.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+-----------------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready   | tuser: command; tdata: gradient, weight,
//           |     |                        |        out_index, deriv_value
//  m_axis   | out | m_axis_tvalid/tready   | tuser: saturated; tdata: result_index,
//           |     |                        |        gradient_out
//
//  One item per cycle while the output queue has room; accumulate items give no result.
//  An emit result passes stage 1 (read and multiply), then stage 2 (scale), and is then
//  written to the output queue, from which m_axis presents it once it is at the head.
//  The memory has separate read and write ports; last cycle's write is forwarded.
//  Reset (synchronous, active low) empties pipeline and queue and clears the valid bits.
//  s_axis_tready drops while queued plus in-flight emits reach the four-entry queue depth.
`include "dense_backprop_gradient_accumulator_core_defines.svh"
module dense_backprop_gradient_accumulator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // gradient, weight, out_index, deriv_value
    input  logic [0:0]  s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // result_index, gradient_out
    output logic [0:0]  m_axis_tuser    // saturated
);
    import dbga_pkg::*;

    // Input unpack
    logic                     accept_in;
    t_cmd                     in_cmd;
    logic signed [GRAD_W-1:0] in_grad;
    logic signed [GRAD_W-1:0] in_weight;
    logic [IDX_W-1:0]         in_idx;
    logic [DERIV_W-1:0]       in_deriv;

    assign accept_in = s_axis_tvalid && s_axis_tready;
    assign in_cmd    = t_cmd'(s_axis_tuser[0]);
    assign in_grad   = s_axis_tdata[15:0];
    assign in_weight = s_axis_tdata[31:16];
    assign in_idx    = s_axis_tdata[39:32];
    assign in_deriv  = s_axis_tdata[47:40];

    // Stage 1: memory read in flight, product registered
    logic                     r_s1_vld;
    t_cmd                     r_s1_cmd;
    logic [IDX_W-1:0]         r_s1_idx;
    logic                     r_s1_inr;
    logic signed [PROD_W-1:0] r_s1_prod;
    logic [DERIV_W-1:0]       r_s1_deriv;

    // Write forwarding and per-entry valid bits
    logic                     r_fw_vld;
    logic [ADDR_W-1:0]        r_fw_addr;
    logic [ACC_W-1:0]         r_fw_data;
    logic [MAX_OUTPUTS-1:0]   r_ent_vld;

    // Stage 2: scaled emit value
    logic                      r_s2_vld;
    logic [IDX_W-1:0]          r_s2_idx;
    logic signed [SCALE_W-1:0] r_s2_scale;

    // Output queue
    t_result              r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wp;
    logic [FIFO_AW-1:0]   r_rp;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     n_cnt;
    logic [CNT_W-1:0]     credit_sum;
    logic                 push;
    logic                 pop;

    t_acc_rd              acc_rd;
    t_acc_wr              acc_wr;
    logic [ACC_W-1:0]     ram_rd_data;
    logic [ADDR_W-1:0]    s1_addr;
    logic [ACC_W-1:0]     acc_old;
    logic signed [SHIFT_W-1:0] acc_shift;
    logic signed [SCALE_W-1:0] scale_val;
    logic                 s1_emit;
    t_result              res_new;

    // Read the addressed accumulator as the item is taken
    assign acc_rd.en   = accept_in;
    assign acc_rd.addr = in_idx[ADDR_W-1:0];

    dbga_acc_ram u_acc_ram (
        .i_clk     (i_clk),
        .i_rd      (acc_rd),
        .i_wr      (acc_wr),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= accept_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_s1_cmd   <= in_cmd;
            r_s1_idx   <= in_idx;
            r_s1_inr   <= {1'b0, in_idx} < OUT_LIMIT;
            r_s1_prod  <= in_grad * in_weight;
            r_s1_deriv <= in_deriv;
        end
    end

    assign s1_addr = r_s1_idx[ADDR_W-1:0];
    assign s1_emit = r_s1_vld && (r_s1_cmd == CMD_EMIT);

    // Last cycle's write wins over the stale read; unwritten entries read zero
    always_comb begin
        if (r_fw_vld && (r_fw_addr == s1_addr)) begin
            acc_old = r_fw_data;
        end else if (r_ent_vld[s1_addr]) begin
            acc_old = ram_rd_data;
        end else begin
            acc_old = '0;
        end
    end

    // Accumulate adds the product; emit clears the entry
    always_comb begin
        acc_wr.en   = r_s1_vld && r_s1_inr;
        acc_wr.addr = s1_addr;
        if (r_s1_cmd == CMD_EMIT) begin
            acc_wr.data = '0;
        end else begin
            acc_wr.data = acc_old + {{(ACC_W - PROD_W){r_s1_prod[PROD_W-1]}}, r_s1_prod};
        end
    end

    // Floor shift is an arithmetic shift: keep the upper bits
    assign acc_shift = acc_old[ACC_W-1:FRAC_BITS];

    always_comb begin
        if (r_s1_inr) begin
            scale_val = acc_shift * $signed({1'b0, r_s1_deriv});
        end else begin
            scale_val = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_vld  <= 1'b0;
            r_ent_vld <= '0;
        end else begin
            r_fw_vld <= acc_wr.en;
            if (acc_wr.en) begin
                r_ent_vld[acc_wr.addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fw_addr <= acc_wr.addr;
        r_fw_data <= acc_wr.data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_emit) begin
            r_s2_idx   <= r_s1_idx;
            r_s2_scale <= scale_val;
        end
    end

    // Clip to 16 bits and flag it
    always_comb begin
        res_new.idx = r_s2_idx;
        if (r_s2_scale > SAT_HI) begin
            res_new.grad = SAT_HI[GRAD_W-1:0];
            res_new.sat  = 1'b1;
        end else if (r_s2_scale < SAT_LO) begin
            res_new.grad = SAT_LO[GRAD_W-1:0];
            res_new.sat  = 1'b1;
        end else begin
            res_new.grad = r_s2_scale[GRAD_W-1:0];
            res_new.sat  = 1'b0;
        end
    end

    assign push = r_s2_vld;
    assign pop  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wp] <= res_new;
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= r_wp + FIFO_AW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + FIFO_AW'(1);
            end
        end
    end

    // Take an item only when every emit in flight has a queue slot
    assign credit_sum    = r_cnt + CNT_W'(s1_emit) + CNT_W'(r_s2_vld);
    assign s_axis_tready = credit_sum < CNT_W'(FIFO_DEPTH);

    assign m_axis_tvalid   = r_cnt != '0;
    assign m_axis_tdata    = {r_fifo[r_rp].grad, r_fifo[r_rp].idx};
    assign m_axis_tuser[0] = r_fifo[r_rp].sat;

    `DBGA_ASSERT(a_no_overflow, push |-> (r_cnt != CNT_W'(FIFO_DEPTH)), "result queue overflow")
    `DBGA_ASSERT(a_credit_bound, credit_sum <= CNT_W'(FIFO_DEPTH), "emit credit exceeded")
    `DBGA_ASSERT(a_emit_result, (accept_in && (in_cmd == CMD_EMIT)) |-> ##2 push, "emit lost")
    `DBGA_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> ((r_cnt == '0) && !r_s1_vld), "not empty")

endmodule

>>> hdl/dbga_acc_ram.sv
// Accumulator store: one write port, one read port with registered read data.
module dbga_acc_ram (
    input  logic                        i_clk,
    input  dbga_pkg::t_acc_rd           i_rd,
    input  dbga_pkg::t_acc_wr           i_wr,
    output logic [dbga_pkg::ACC_W-1:0]  o_rd_data
);
    import dbga_pkg::*;

    logic [ACC_W-1:0] r_mem [MAX_OUTPUTS];
    logic [ACC_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Read returns the old contents on a same-address collision.
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> dv/dense_backprop_gradient_accumulator_core_tb.sv
// Self-checking testbench for the dense-layer backprop gradient accumulator core.
`timescale 1ns / 100ps
module dense_backprop_gradient_accumulator_core_tb;
    import dbga_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 1600;
    localparam int EARLY_ITEMS  = 400;
    localparam int CALM_ITEMS   = 250;
    localparam int WRAP_RUN     = 513;
    localparam int LONG_HOLD    = 120;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 400000;

    localparam longint GRAD_MAX = 32767;
    localparam longint GRAD_MIN = -32768;

    // One item as the sender sees it.
    typedef struct packed {
        t_cmd               cmd;
        logic [GRAD_W-1:0]  grad;
        logic [GRAD_W-1:0]  weight;
        logic [IDX_W-1:0]   idx;
        logic [DERIV_W-1:0] deriv;
    } bp_item_t;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;    // gradient, weight, out_index, deriv_value
    logic [0:0]  s_axis_tuser  = '0;    // command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // result_index, gradient_out
    logic [0:0]  m_axis_tuser;          // saturated

    bp_item_t pending_items[$];
    t_result  emits_due[$];
    logic signed [ACC_W-1:0] grad_sums [MAX_OUTPUTS];

    logic item_taken     = 1'b0;
    logic gaps_on        = 1'b0;
    logic long_stall_req = 1'b0;
    logic rx_long_hold   = 1'b0;
    int   send_gap       = 0;
    int   recv_gap       = 0;
    int   mismatch_count = 0;
    int   cycle_count    = 0;

    dense_backprop_gradient_accumulator_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin : clock_gen
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    function automatic void queue_item(t_cmd cmd, int grad, int weight, int idx, int deriv);
        bp_item_t it;
        it.cmd    = cmd;
        it.grad   = GRAD_W'(grad);
        it.weight = GRAD_W'(weight);
        it.idx    = IDX_W'(idx);
        it.deriv  = DERIV_W'(deriv);
        pending_items.push_back(it);
    endfunction

    // Half the operands use all 16 bits, half stay near zero so sums survive the scaling.
    function automatic int rand_operand();
        if ($urandom_range(0, 1))
            return int'($urandom_range(0, 65535));
        return int'($urandom_range(0, 1200)) - 600;
    endfunction

    // Mostly accumulate runs closed by an emit; the rest lone items and unfinished runs.
    function automatic void push_random_runs(int count);
        int added;
        int kind;
        int idx;
        int run_len;
        added = 0;
        while (added < count) begin
            kind = $urandom_range(0, 9);
            idx  = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 255);
            if (kind <= 6) begin
                run_len = $urandom_range(1, 12);
                repeat (run_len)
                    queue_item(CMD_ACC, rand_operand(), rand_operand(), idx,
                               $urandom_range(0, 255));
                queue_item(CMD_EMIT, $urandom_range(0, 65535), $urandom_range(0, 65535), idx,
                           $urandom_range(0, 255));
                added += run_len + 1;
            end else if (kind <= 8) begin
                queue_item($urandom_range(0, 1) ? CMD_EMIT : CMD_ACC,
                           $urandom_range(0, 65535), $urandom_range(0, 65535), idx,
                           $urandom_range(0, 255));
                added += 1;
            end else begin
                // leave a partial sum behind for some later emit
                run_len = $urandom_range(1, 4);
                repeat (run_len)
                    queue_item(CMD_ACC, rand_operand(), rand_operand(), idx,
                               $urandom_range(0, 255));
                added += run_len;
            end
        end
    endfunction

    // Track the accumulators and queue the result an emit should produce.
    function automatic void apply_item(bp_item_t it);
        logic signed [PROD_W-1:0] prod;
        longint  scaled;
        t_result res;
        if (it.cmd == CMD_ACC) begin
            if (it.idx < MAX_OUTPUTS) begin
                prod = $signed(it.grad) * $signed(it.weight);
                // 40-bit sum, wraps on overflow
                grad_sums[it.idx] = grad_sums[it.idx]
                                  + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
            end
        end else begin
            res.idx  = it.idx;
            res.grad = '0;
            res.sat  = 1'b0;
            if (it.idx < MAX_OUTPUTS) begin
                // floor shift back to the input format, derivative byte as an integer
                scaled = longint'(grad_sums[it.idx] >>> FRAC_BITS) * longint'(it.deriv);
                grad_sums[it.idx] = '0;
                if (scaled > GRAD_MAX) begin
                    res.grad = GRAD_W'(GRAD_MAX);
                    res.sat  = 1'b1;
                end else if (scaled < GRAD_MIN) begin
                    res.grad = GRAD_W'(GRAD_MIN);
                    res.sat  = 1'b1;
                end else begin
                    res.grad = scaled[GRAD_W-1:0];
                end
            end
            emits_due.push_back(res);
        end
    endfunction

    // Hold until the sender is empty and every emit has come back.
    task automatic drain_all();
        while (pending_items.size() != 0 || s_axis_tvalid || emits_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Sender: present the next item once the current one is taken.
    always @(negedge i_clk) begin : driver
        bp_item_t nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || item_taken) begin
            if (send_gap > 0) begin
                send_gap      <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_items.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else begin
                nxt = pending_items.pop_front();
                s_axis_tdata  <= {nxt.deriv, nxt.idx, nxt.weight, nxt.grad};
                s_axis_tuser  <= nxt.cmd;
                s_axis_tvalid <= 1'b1;
                if (gaps_on && $urandom_range(0, 7) == 0)
                    send_gap <= $urandom_range(1, 9);
            end
        end
    end

    // Receiver: random stall bursts, plus the long hold-off when asked.
    always @(negedge i_clk) begin : receiver
        if (recv_gap > 0) begin
            recv_gap      <= recv_gap - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_long_hold) begin
            m_axis_tready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            recv_gap      <= $urandom_range(0, 8);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Long hold-offs on the result side so the output queue fills and backs up the input.
    initial begin : long_stall
        while (!long_stall_req)
            @(negedge i_clk);
        repeat ($urandom_range(100, 300)) @(negedge i_clk);
        rx_long_hold <= 1'b1;
        repeat (LONG_HOLD) @(negedge i_clk);
        rx_long_hold <= 1'b0;
        repeat ($urandom_range(20, 100)) @(negedge i_clk);
        rx_long_hold <= 1'b1;
        repeat (LONG_HOLD) @(negedge i_clk);
        rx_long_hold <= 1'b0;
    end

    // Check results against the oldest expectation, then track accepted items.
    always @(posedge i_clk) begin : monitor
        t_result  got;
        t_result  want;
        bp_item_t seen;
        if (!i_rst_n) begin
            item_taken <= 1'b0;
        end else begin
            item_taken <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                got.idx  = m_axis_tdata[IDX_W-1:0];
                got.grad = m_axis_tdata[IDX_W+GRAD_W-1:IDX_W];
                got.sat  = m_axis_tuser[0];
                if (emits_due.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual index %0d grad %0d sat %0b",
                             $time, got.idx, $signed(got.grad), got.sat);
                    mismatch_count++;
                end else begin
                    want = emits_due.pop_front();
                    if (got.idx !== want.idx) begin
                        $display("%0t: result_index expected %0d actual %0d",
                                 $time, want.idx, got.idx);
                        mismatch_count++;
                    end
                    if (got.grad !== want.grad) begin
                        $display("%0t: gradient_out (index %0d) expected %0d actual %0d",
                                 $time, want.idx, $signed(want.grad), $signed(got.grad));
                        mismatch_count++;
                    end
                    if (got.sat !== want.sat) begin
                        $display("%0t: saturated (index %0d) expected %0b actual %0b",
                                 $time, want.idx, want.sat, got.sat);
                        mismatch_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                seen.grad   = s_axis_tdata[GRAD_W-1:0];
                seen.weight = s_axis_tdata[2*GRAD_W-1:GRAD_W];
                seen.idx    = s_axis_tdata[2*GRAD_W+IDX_W-1:2*GRAD_W];
                seen.deriv  = s_axis_tdata[47:2*GRAD_W+IDX_W];
                seen.cmd    = t_cmd'(s_axis_tuser[0]);
                apply_item(seen);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d items and %0d results outstanding",
                     $time, pending_items.size(), emits_due.size());
            $display("dense_backprop_gradient_accumulator_core_tb: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int k;
        for (k = 0; k < MAX_OUTPUTS; k++)
            grad_sums[k] = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, clipping at both ends, floor rounding, reuse after clear.
        queue_item(CMD_EMIT, 0, 0, 0, 255);             // empty accumulator gives zero
        queue_item(CMD_ACC, 32767, 32767, 0, 255);      // derivative byte ignored here
        queue_item(CMD_EMIT, -1, -1, 0, 1);             // clips high; operands ignored
        queue_item(CMD_EMIT, 0, 0, 0, 1);               // cleared by the last emit
        queue_item(CMD_ACC, -32768, -32768, 255, 0);
        queue_item(CMD_ACC, -32768, 32767, 255, 0);
        queue_item(CMD_EMIT, 0, 0, 255, 0);             // zero derivative
        queue_item(CMD_ACC, 1, -1, 1, 0);
        queue_item(CMD_EMIT, 0, 0, 1, 5);               // minus one LSB floors to -1
        queue_item(CMD_ACC, -32768, 32767, 2, 0);
        queue_item(CMD_EMIT, 0, 0, 2, 255);             // clips low
        queue_item(CMD_ACC, 4681, 4096, 3, 0);
        queue_item(CMD_EMIT, 0, 0, 3, 7);               // exactly the top of range
        queue_item(CMD_ACC, -4096, 4096, 4, 0);
        queue_item(CMD_EMIT, 0, 0, 4, 8);               // exactly the bottom of range
        queue_item(CMD_ACC, -4097, 4096, 5, 0);
        queue_item(CMD_EMIT, 0, 0, 5, 8);               // eight below the bottom, clips low
        queue_item(CMD_ACC, 4096, 4096, 6, 0);
        queue_item(CMD_EMIT, 0, 0, 6, 1);
        queue_item(CMD_ACC, 8192, 4096, 6, 0);          // same output right after its emit
        queue_item(CMD_ACC, 8192, 4096, 6, 0);
        queue_item(CMD_EMIT, 0, 0, 6, 1);
        queue_item(CMD_ACC, 4096, 4096, 128, 0);
        queue_item(CMD_EMIT, 0, 0, 128, 2);
        drain_all();

        gaps_on        = 1'b1;
        long_stall_req = 1'b1;
        push_random_runs(EARLY_ITEMS);
        // Largest product into one output until the 40-bit sum wraps negative.
        repeat (WRAP_RUN) queue_item(CMD_ACC, -32768, -32768, 9, 0);
        queue_item(CMD_EMIT, 0, 0, 9, 1);

        // Pause the sender until every result is back.
        drain_all();
        push_random_runs(RANDOM_ITEMS - EARLY_ITEMS - WRAP_RUN - 1 - CALM_ITEMS);
        while (pending_items.size() != 0)
            @(posedge i_clk);

        // Closing stretch at full rate on both sides.
        gaps_on = 1'b0;
        push_random_runs(CALM_ITEMS);
        drain_all();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("dense_backprop_gradient_accumulator_core_tb: PASS");
        else
            $display("dense_backprop_gradient_accumulator_core_tb: FAIL");
        $finish;
    end

endmodule
